// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the matcher checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked property, checked in and out of reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/core/lmw_pkg.sv =====
`default_nettype none
package lmw_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_EVAL   = 2'd3
  } func_e;

  // Wildcard bytes
  localparam logic [7:0] ANY_RUN = 8'h25;  // '%'
  localparam logic [7:0] ANY_ONE = 8'h5F;  // '_'

  localparam int unsigned MAX_PATTERN_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Control part of a queued item; the hit vector travels beside it
  typedef struct packed {
    func_e func;
    logic  is_run;  // appended byte is '%'
  } lmw_ctl_t;

  localparam int unsigned CTL_W = $bits(lmw_ctl_t);

endpackage
`default_nettype wire

// ===== rtl/core/lmw_fifo.sv =====
`default_nettype none
module lmw_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      pop_data_o
);
  import lmw_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign ready_o    = (count_q != CW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lmw_front.sv =====
`default_nettype none
module lmw_front #(
  parameter int unsigned MAX_PATTERN = lmw_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire lmw_pkg::func_e         func_i,
  input  wire logic [7:0]             byte_value_i,
  input  wire logic                   q_ready_i,
  output logic                        q_push_o,
  output lmw_pkg::lmw_ctl_t           q_ctl_o,
  output logic [MAX_PATTERN-1:0]      q_hit_o
);
  import lmw_pkg::*;

  localparam int unsigned N = MAX_PATTERN;

  logic [7:0]   store_q [N];
  logic [N-1:0] fill_q, fill_d;  // thermometer of stored bytes
  logic [N-1:0] wr_en;
  logic         accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign q_push_o   = accept;

  assign q_ctl_o.func   = func_i;
  assign q_ctl_o.is_run = (byte_value_i == ANY_RUN);

  // Per position: store write enable; hit = byte consumed and position advances ('%' positions excluded)
  for (genvar p = 0; p < N; p++) begin : g_pos
    logic prev_full;
    if (p == 0) begin : g_first
      assign prev_full = 1'b1;
    end else begin : g_rest
      assign prev_full = fill_q[p-1];
    end
    assign wr_en[p] = accept && (func_i == FUNC_APPEND) && !fill_q[p] && prev_full;
    assign q_hit_o[p] = fill_q[p] && (store_q[p] != ANY_RUN) &&
                        ((store_q[p] == ANY_ONE) || (store_q[p] == byte_value_i));

    always_ff @(posedge clk_i) begin
      if (wr_en[p]) begin
        store_q[p] <= byte_value_i;
      end
    end
  end

  // Fill mask update
  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      case (func_i)
        FUNC_CLEAR:  fill_d = '0;
        FUNC_APPEND: fill_d = (fill_q << 1) | N'(1);
        default:     fill_d = fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lmw_back.sv =====
`default_nettype none
module lmw_back #(
  parameter int unsigned MAX_PATTERN = lmw_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  output logic                        q_pop_o,
  input  wire lmw_pkg::lmw_ctl_t      q_ctl_i,
  input  wire logic [MAX_PATTERN-1:0] q_hit_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        matched_o,
  output logic                        overflow_o
);
  import lmw_pkg::*;

  localparam int unsigned N = MAX_PATTERN;

  // Closes a position set over '%': a position on '%' enables the next one,
  // chained. Solved as a carry chain: generate = seed, propagate = '%' below.
  function automatic logic [N:0] close_runs(input logic [N:0] seed,
                                            input logic [N-1:0] runs);
    logic [N:0]   prop;
    logic [N:0]   a;
    logic [N+1:0] sum;
    logic [N+1:0] carry;
    prop  = {runs, 1'b0};
    a     = seed | prop;
    sum   = {1'b0, a} + {1'b0, seed};
    carry = sum ^ {1'b0, a} ^ {1'b0, seed};
    return carry[N+1:1];
  endfunction

  logic [N:0]   active_q, active_d;  // kept closed over '%'
  logic [N-1:0] runs_q, runs_d;      // '%' positions of the pattern
  logic [N:0]   end_q, end_d;        // one-hot pattern length
  logic         ovf_q, ovf_d;
  logic         out_valid_q, out_valid_d;
  logic         matched_q, matched_d;
  logic         overflow_q, overflow_d;
  logic         slot_free;
  logic [N:0]   seed;
  logic [N-1:0] seed_runs;
  logic [N-1:0] live;

  assign slot_free = !out_valid_q || out_ready_i;
  assign q_pop_o   = q_valid_i && ((q_ctl_i.func != FUNC_EVAL) || slot_free);
  assign live      = active_q[N-1:0];

  // Pattern shape, result and closure seed
  always_comb begin
    runs_d      = runs_q;
    end_d       = end_q;
    ovf_d       = ovf_q;
    seed        = (N+1)'(1);
    seed_runs   = runs_q;
    out_valid_d = out_valid_q && !out_ready_i;
    matched_d   = matched_q;
    overflow_d  = overflow_q;
    if (q_pop_o) begin
      unique case (q_ctl_i.func)
        FUNC_CLEAR: begin
          runs_d    = '0;
          end_d     = (N+1)'(1);
          ovf_d     = 1'b0;
          seed_runs = '0;
        end
        FUNC_APPEND: begin
          if (end_q[N]) begin
            ovf_d = 1'b1;
          end else begin
            runs_d = runs_q | (end_q[N-1:0] & {N{q_ctl_i.is_run}});
            end_d  = end_q << 1;
          end
          seed_runs = runs_d;
        end
        FUNC_TEXT: begin
          seed = {live & q_hit_i, 1'b0} | {1'b0, live & runs_q};
        end
        FUNC_EVAL: begin
          out_valid_d = 1'b1;
          matched_d   = (|(active_q & end_q)) && !ovf_q;
          overflow_d  = ovf_q;
        end
        default: begin
          seed = (N+1)'(1);
        end
      endcase
    end
  end

  assign active_d = q_pop_o ? close_runs(seed, seed_runs) : active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= (N+1)'(1);
      runs_q      <= '0;
      end_q       <= (N+1)'(1);
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      runs_q      <= runs_d;
      end_q       <= end_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    matched_q  <= matched_d;
    overflow_q <= overflow_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign overflow_o  = overflow_q;

endmodule
`default_nettype wire

// ===== rtl/core/like_wildcard_matcher.sv =====
// SQL LIKE matcher. Input beats carry a kind in tuser (clear, append pattern
// byte, text byte, evaluate) and a byte in tdata. '%' matches any run of bytes,
// '_' exactly one byte, anything else itself, case-sensitively. Only an
// evaluate beat yields an output beat: bit 0 matched, bit 1 overflow (more than
// MAX_PATTERN bytes appended since the last clear; matched then reads 0).
// Appending or evaluating restarts the text. One beat is taken per cycle while
// the queue has room; the front stage compares the byte against every stored
// pattern byte at once and the back stage updates the active position set
// with a single carry-chain add, so the rate is one beat per clock unless the
// output stalls. An evaluate result passes the queue, then the output register;
// a two-entry queue between the stages absorbs output back-pressure.
`default_nettype none
module like_wildcard_matcher #(
  parameter int unsigned MAX_PATTERN = lmw_pkg::MAX_PATTERN_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic [1:0] s_axis_tuser_i,   // [1:0] func
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [0] matched, [1] overflow, [7:2] zero
);
  import lmw_pkg::*;

  localparam int unsigned QW = MAX_PATTERN + CTL_W;

  logic                   q_push, q_ready, q_pop, q_valid;
  lmw_ctl_t               push_ctl, pop_ctl;
  logic [MAX_PATTERN-1:0] push_hit, pop_hit;
  logic [QW-1:0]          pop_data;
  logic                   matched, overflow;

  lmw_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .func_i       (func_e'(s_axis_tuser_i)),
    .byte_value_i (s_axis_tdata_i),
    .q_ready_i    (q_ready),
    .q_push_o     (q_push),
    .q_ctl_o      (push_ctl),
    .q_hit_o      (push_hit)
  );

  lmw_fifo #(.WIDTH(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({push_hit, push_ctl}),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  assign pop_ctl = lmw_ctl_t'(pop_data[CTL_W-1:0]);
  assign pop_hit = pop_data[QW-1:CTL_W];

  lmw_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_ctl_i     (pop_ctl),
    .q_hit_i     (pop_hit),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .matched_o   (matched),
    .overflow_o  (overflow)
  );

  assign m_axis_tdata_o = {6'b0, overflow, matched};

endmodule
`default_nettype wire

// ===== rtl/core/lmw_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module lmw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  logic out_stall;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // A stalled result beat stays put
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // Overflow forces the match off
  `ASSERT_RST(a_ovf_no_match, clk_i, rst_ni, m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))

  // Padding bits of a result beat are zero
  `ASSERT_RST(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[7:2] == 6'b0))

  // No result beat shows during reset
  `ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind like_wildcard_matcher lmw_checker u_lmw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

// ===== dv/like_wildcard_matcher_tb.sv =====
`timescale 1ns / 1ps
module like_wildcard_matcher_tb;
  import lmw_pkg::*;

  localparam int unsigned MAX_PAT     = MAX_PATTERN_DEF;
  localparam int unsigned ITEM_TARGET = 700;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One evaluate verdict
  typedef struct packed {
    logic overflow;
    logic matched;
  } verdict_t;

  typedef logic [7:0] byte_q_t[$];

  // Tracks pattern, active positions and overflow; queues verdicts per evaluate
  class match_scoreboard;
    logic [7:0]     pat [MAX_PAT];
    int unsigned    pat_len;
    logic [MAX_PAT:0] live;
    logic           too_long;
    verdict_t       verdicts[$];
    int             errors;

    function new();
      pat_len  = 0;
      too_long = 1'b0;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      live    = '0;
      live[0] = 1'b1;
    endfunction

    // an active '%' also enables the position after it; chains propagate
    function void spread_runs();
      int p;
      for (p = 0; p < pat_len; p++) begin
        if (live[p] && pat[p] == ANY_RUN) live[p+1] = 1'b1;
      end
    endfunction

    function void step_text(logic [7:0] b);
      logic [MAX_PAT:0] nxt;
      int p;
      spread_runs();
      nxt = '0;
      for (p = 0; p < pat_len; p++) begin
        if (live[p]) begin
          if (pat[p] == ANY_RUN) nxt[p] = 1'b1;
          else if (pat[p] == ANY_ONE || pat[p] == b) nxt[p+1] = 1'b1;
        end
      end
      live = nxt;
    endfunction

    function void note_input(func_e f, logic [7:0] b);
      verdict_t v;
      case (f)
        FUNC_CLEAR: begin
          pat_len  = 0;
          too_long = 1'b0;
          restart();
        end
        FUNC_APPEND: begin
          if (pat_len < MAX_PAT) begin
            pat[pat_len] = b;
            pat_len++;
          end else begin
            too_long = 1'b1;
          end
          restart();
        end
        FUNC_TEXT: step_text(b);
        default: begin
          spread_runs();
          v.matched  = live[pat_len] && !too_long;
          v.overflow = too_long;
          verdicts.push_back(v);
          restart();
        end
      endcase
    endfunction

    function void check_result(logic [7:0] d);
      verdict_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: result with none expected, tdata=%h", $time, d);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (d[0] !== want.matched) begin
        $display("%0t: matched mismatch, expected %b actual %b", $time, want.matched, d[0]);
        errors++;
      end
      if (d[1] !== want.overflow) begin
        $display("%0t: overflow mismatch, expected %b actual %b", $time, want.overflow, d[1]);
        errors++;
      end
      if (d[7:2] !== 6'd0) begin
        $display("%0t: tdata pad mismatch, expected %h actual %h", $time, 6'd0, d[7:2]);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni   = 1'b1;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'd0;
  logic [1:0] s_tuser  = 2'd0;
  logic       m_tready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;

  match_scoreboard sb;
  int unsigned     items_sent = 0;
  int unsigned     burst_left = 0;
  int unsigned     cycle_count = 0;
  int unsigned     stall_phase = 0;

  like_wildcard_matcher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("like_wildcard_matcher_tb failed");
      $finish;
    end
  end

  // Result side: check accepted beats, stall in phases of varying density
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o);
    stall_phase++;
    case (stall_phase[8:7])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_phase[2:0] < 3'd5);
    endcase
  end

  // Drive one beat; sender runs in bursts with random gaps
  task automatic send_item(func_e f, logic [7:0] b);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(f, b);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending until every evaluate verdict has come back
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    burst_left = $urandom_range(1, 16);
  endtask

  function automatic logic [7:0] pick_pat_byte();
    case ($urandom_range(0, 9))
      0, 1:    return "a";
      2:       return "b";
      3, 4:    return ANY_RUN;
      5, 6:    return ANY_ONE;
      7:       return "c";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 5))
      0, 1:    return "a";
      2:       return "b";
      3:       return "c";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Text that fits the current pattern, sometimes damaged afterwards
  function automatic byte_q_t make_text();
    byte_q_t txt;
    int unsigned p;
    int unsigned i;
    txt = {};
    for (p = 0; p < sb.pat_len; p++) begin
      if (sb.pat[p] == ANY_RUN) begin
        repeat ($urandom_range(0, 3)) txt.push_back(pick_text_byte());
      end else if (sb.pat[p] == ANY_ONE) begin
        txt.push_back(pick_text_byte());
      end else begin
        txt.push_back(sb.pat[p]);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      i = (txt.size() == 0) ? 0 : $urandom_range(0, txt.size() - 1);
      case ($urandom_range(0, 2))
        0: if (txt.size() != 0) txt[i] = pick_text_byte();
        1: if (txt.size() != 0) txt.delete(i);
        default: txt.insert(i, pick_text_byte());
      endcase
    end
    return txt;
  endfunction

  // Clear (usually), load a pattern of plen bytes, then run a few texts; now and then only random beats
  task automatic run_sequence(int unsigned plen);
    byte_q_t txt;
    logic [1:0] f;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        f = 2'($urandom_range(0, 3));
        send_item(func_e'(f), 8'($urandom_range(0, 255)));
      end
      return;
    end
    if ($urandom_range(0, 3) != 0) send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)));
    repeat (plen) send_item(FUNC_APPEND, pick_pat_byte());
    repeat ($urandom_range(1, 3)) begin
      txt = make_text();
      foreach (txt[k]) begin
        if ($urandom_range(0, 40) == 0) send_item(FUNC_APPEND, pick_pat_byte());
        send_item(FUNC_TEXT, txt[k]);
      end
      send_item(FUNC_EVAL, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned next_drain;
    int unsigned plen;
    sb = new();
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pattern: only the empty text matches
    send_item(FUNC_EVAL, 8'hFF);
    send_item(FUNC_TEXT, "a");
    send_item(FUNC_EVAL, 8'h00);
    // lone '%' matches empty and any text, extreme byte values
    send_item(FUNC_APPEND, ANY_RUN);
    send_item(FUNC_EVAL, 8'h00);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_EVAL, 8'hFF);
    // clear, then "_A%" with an append arriving mid-text
    send_item(FUNC_CLEAR, 8'hA5);
    send_item(FUNC_APPEND, ANY_ONE);
    send_item(FUNC_APPEND, "A");
    send_item(FUNC_TEXT, "z");
    send_item(FUNC_APPEND, ANY_RUN);
    send_item(FUNC_TEXT, "q");
    send_item(FUNC_TEXT, "A");
    send_item(FUNC_TEXT, "x");
    send_item(FUNC_EVAL, 8'h5A);
    // case sensitivity, and '_' needs exactly one byte
    send_item(FUNC_TEXT, "q");
    send_item(FUNC_TEXT, "a");
    send_item(FUNC_EVAL, 8'h00);
    send_item(FUNC_EVAL, 8'h00);
    hold_until_drained();

    // overflow by one, then a full store, then random sequences
    run_sequence(MAX_PAT + 1);
    run_sequence(MAX_PAT);
    next_drain = items_sent + 150;
    while (items_sent < ITEM_TARGET) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
      run_sequence(plen);
      if (items_sent >= next_drain) begin
        hold_until_drained();
        next_drain = items_sent + 150;
      end
    end

    hold_until_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("like_wildcard_matcher_tb passed");
    end else begin
      $display("like_wildcard_matcher_tb failed");
    end
    $finish;
  end

endmodule
